### rtl/crc_rfc_pkg.sv
// ----------------------------------------------------------------------------
// crc_rfc_pkg
// Shared types, constants and the CRC-32 byte update for the record checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package crc_rfc_pkg;

  localparam int unsigned HeaderLen = 8;
  localparam int unsigned FifoDepthDefault = 4;

  localparam logic [31:0] CrcPoly   = 32'hEDB8_8320;
  localparam logic [31:0] CrcPreset = 32'hFFFF_FFFF;
  localparam logic [31:0] CountMax  = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    VERDICT_OK     = 2'd0,
    VERDICT_SHORT  = 2'd1,
    VERDICT_LENGTH = 2'd2,
    VERDICT_CRC    = 2'd3
  } verdict_e;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       is_verdict;
    logic [1:0] verdict;
  } item_t;

  // Up to two result items caused by one input transaction.
  typedef struct packed {
    logic [1:0] count;
    item_t      item0;
    item_t      item1;
  } push_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

### rtl/crc_rfc_if.sv
// ----------------------------------------------------------------------------
// crc_rfc_if
// Valid/ready channels: record bytes in, payload and verdict items out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface crc_rfc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_record;

  modport source (output valid, output data_byte, output end_of_record, input ready);
  modport sink   (input valid, input data_byte, input end_of_record, output ready);
endinterface

interface crc_rfc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] payload_byte;
  logic       is_verdict;
  logic [1:0] verdict;

  modport source (output valid, output payload_byte, output is_verdict, output verdict,
                  input ready);
  modport sink   (input valid, input payload_byte, input is_verdict, input verdict,
                  output ready);
endinterface

`default_nettype wire

### rtl/crc_rfc_core.sv
// ----------------------------------------------------------------------------
// crc_rfc_core
// Record state: header capture, saturating byte count, CRC and verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module crc_rfc_core (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                accept_i,
  input  wire logic [7:0]          data_byte_i,
  input  wire logic                end_of_record_i,
  output crc_rfc_pkg::push_t       push_o
);
  import crc_rfc_pkg::*;

  logic [63:0] header_q, header_d;
  logic [31:0] seen_q, seen_d, seen_inc;
  logic [31:0] crc_q, crc_d;
  logic        in_header;
  verdict_e    verdict;
  item_t       pay_item, ver_item;

  assign in_header = (seen_q[31:3] == 29'd0);
  assign seen_inc  = (seen_q == CountMax) ? seen_q : seen_q + 32'd1;

  always_comb begin
    header_d = header_q;
    crc_d    = crc_q;
    if (in_header) begin
      header_d = header_q | ({56'd0, data_byte_i} << {seen_q[2:0], 3'b000});
    end else begin
      crc_d = crc_byte(crc_q, data_byte_i);
    end
    seen_d = seen_inc;
  end

  always_comb begin
    priority if (seen_inc[31:3] == 29'd0) begin
      verdict = VERDICT_SHORT;
    end else if ((seen_inc == CountMax) ||
                 ((seen_inc - 32'd8) != header_d[63:32])) begin
      verdict = VERDICT_LENGTH;
    end else if ((crc_d ^ CrcPreset) != header_d[31:0]) begin
      verdict = VERDICT_CRC;
    end else begin
      verdict = VERDICT_OK;
    end
  end

  always_comb begin
    pay_item = '{payload_byte: data_byte_i, is_verdict: 1'b0, verdict: VERDICT_OK};
    ver_item = '{payload_byte: 8'd0, is_verdict: 1'b1, verdict: verdict};
    push_o   = '0;
    if (accept_i) begin
      push_o.count = {1'b0, ~in_header} + {1'b0, end_of_record_i};
      push_o.item0 = in_header ? ver_item : pay_item;
      push_o.item1 = ver_item;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_q <= '0;
      seen_q   <= '0;
      crc_q    <= CrcPreset;
    end else if (accept_i) begin
      if (end_of_record_i) begin
        header_q <= '0;
        seen_q   <= '0;
        crc_q    <= CrcPreset;
      end else begin
        header_q <= header_d;
        seen_q   <= seen_d;
        crc_q    <= crc_d;
      end
    end
  end

  a_reset_after_verdict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && end_of_record_i) |=> (seen_q == 32'd0 && crc_q == CrcPreset))
    else $error("record state not cleared after verdict");

  a_pair_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o.count == 2'd2) |-> (!push_o.item0.is_verdict && push_o.item1.is_verdict))
    else $error("payload must precede verdict");

  a_payload_after_header: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o.count != 2'd0 && !push_o.item0.is_verdict) |-> (seen_q[31:3] != 29'd0))
    else $error("payload forwarded inside header");

  a_no_push_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept_i |-> (push_o.count == 2'd0))
    else $error("push without input transaction");

endmodule

`default_nettype wire

### rtl/crc_rfc_fifo.sv
// ----------------------------------------------------------------------------
// crc_rfc_fifo
// Result queue: takes up to two items per cycle, delivers one per cycle when popped.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module crc_rfc_fifo #(
  parameter int unsigned Depth = crc_rfc_pkg::FifoDepthDefault
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire crc_rfc_pkg::push_t push_i,
  input  wire logic               pop_i,
  output crc_rfc_pkg::item_t      head_o,
  output logic                    not_empty_o,
  output logic                    room2_o
);
  import crc_rfc_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] RoomMin = CntW'(Depth - 2);

  item_t           mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q, wr_inc, wr_inc2, rd_inc;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign wr_inc  = (wr_q == LastPtr) ? '0 : wr_q + PtrW'(1);
  assign wr_inc2 = (wr_inc == LastPtr) ? '0 : wr_inc + PtrW'(1);
  assign rd_inc  = (rd_q == LastPtr) ? '0 : rd_q + PtrW'(1);

  assign head_o      = mem_q[rd_q];
  assign not_empty_o = (cnt_q != '0);
  assign room2_o     = (cnt_q <= RoomMin);

  assign cnt_d = cnt_q + CntW'(push_i.count) - CntW'(pop_i);

  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) begin
      mem_q[wr_q] <= push_i.item0;
    end
    if (push_i.count == 2'd2) begin
      mem_q[wr_inc] <= push_i.item1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (pop_i) begin
        rd_q <= rd_inc;
      end
      unique case (push_i.count)
        2'd1:    wr_q <= wr_inc;
        2'd2:    wr_q <= wr_inc2;
        default: wr_q <= wr_q;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (32'(cnt_q) + 32'(push_i.count)) <= (32'(Depth) + 32'(pop_i)))
    else $error("result queue overflow");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> not_empty_o)
    else $error("pop from empty result queue");

  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_i && push_i.count == 2'd0) |=> (cnt_q == $past(cnt_q) - CntW'(1)))
    else $error("queue count not decremented on drain");

endmodule

`default_nettype wire

### rtl/crc_record_frame_checker.sv
// ----------------------------------------------------------------------------
// crc_record_frame_checker
// Length-prefixed record checker with CRC-32 over the payload.
// ----------------------------------------------------------------------------
// Output: result items are registered in the result queue and offered from its head.
// Throughput: one byte per cycle; the byte state and CRC update finish in the
//   accepting cycle. A final payload byte yields two result items, drained from the
//   queue one per cycle while the receiver is ready; input is taken while two entries are free.
// Reset: header and count cleared, CRC preset to all ones, result queue empty.
`timescale 1ns / 1ps
`default_nettype none

module crc_record_frame_checker #(
  parameter int unsigned FifoDepth = crc_rfc_pkg::FifoDepthDefault
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  crc_rfc_in_if.sink    rec_i,
  crc_rfc_out_if.source res_o
);
  import crc_rfc_pkg::*;

  push_t push;
  item_t head;
  logic  accept, pop, not_empty, room2;

  assign rec_i.ready = room2;
  assign accept      = rec_i.valid && room2;
  assign pop         = not_empty && res_o.ready;

  crc_rfc_core u_core (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (accept),
    .data_byte_i     (rec_i.data_byte),
    .end_of_record_i (rec_i.end_of_record),
    .push_o          (push)
  );

  crc_rfc_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .pop_i       (pop),
    .head_o      (head),
    .not_empty_o (not_empty),
    .room2_o     (room2)
  );

  assign res_o.valid        = not_empty;
  assign res_o.payload_byte = head.payload_byte;
  assign res_o.is_verdict   = head.is_verdict;
  assign res_o.verdict      = head.verdict;

endmodule

`default_nettype wire

### tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for crc_record_frame_checker. Records are built from a
// CRC-32 header, a length field and a random payload, some of them damaged or
// cut short, and are sent one byte per transaction. Each accepted byte goes
// through a behavioral model that queues the payload and verdict items due.
// Each result transaction is compared with the oldest item due. Idle and stall
// patterns change across three phases, and one long receiver hold-off fills
// the block.
// ----------------------------------------------------------------------------

module tb;
  import crc_rfc_pkg::*;

  localparam int unsigned StallLimit    = 5000;
  localparam int unsigned HoldCycles    = 80;
  localparam int unsigned BytesPerPhase = 150;
  localparam int unsigned TailCycles    = 8;

  typedef struct {
    logic [7:0] data;
    logic       last;
  } rec_byte_t;

  typedef logic [7:0] byte_q_t[$];

  logic clk = 1'b0;
  logic rst_n;

  crc_rfc_in_if  rec_if ();
  crc_rfc_out_if res_if ();

  crc_record_frame_checker u_top (
    .clk_i (clk),
    .rst_ni(rst_n),
    .rec_i (rec_if),
    .res_o (res_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  rec_byte_t   queued_bytes[$];
  item_t       due_items[$];
  rec_byte_t   next_byte;
  item_t       oldest_due;
  logic        rec_taken = 1'b0;
  int unsigned send_idle_pct = 31;
  int unsigned recv_idle_pct = 51;
  logic        hold_go = 1'b0;
  int unsigned hold_left = HoldCycles;
  int unsigned quiet_cycles = 0;
  int unsigned err_count = 0;

  // record tracking state
  logic [63:0] hdr_acc   = '0;
  logic [31:0] rec_count = '0;
  logic [31:0] crc_acc   = CrcPreset;

  function automatic logic [31:0] crc32_step(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] r;
    r = c ^ {24'd0, b};
    repeat (8) r = (r >> 1) ^ (CrcPoly & {32{r[0]}});
    return r;
  endfunction

  function automatic logic [31:0] crc32_of(input byte_q_t bytes);
    logic [31:0] c;
    c = CrcPreset;
    foreach (bytes[i]) c = crc32_step(c, bytes[i]);
    return c ^ CrcPreset;
  endfunction

  function automatic void track_record_byte(input logic [7:0] b, input logic last);
    item_t    it;
    verdict_e v;
    if (rec_count < HeaderLen) begin
      hdr_acc[8*rec_count[2:0] +: 8] = b;
    end else begin
      crc_acc = crc32_step(crc_acc, b);
      it.payload_byte = b;
      it.is_verdict   = 1'b0;
      it.verdict      = VERDICT_OK;
      due_items.insert(due_items.size(), it);
    end
    if (rec_count != CountMax) rec_count++;
    if (last) begin
      if (rec_count < HeaderLen) begin
        v = VERDICT_SHORT;
      end else if (rec_count == CountMax || rec_count - HeaderLen != hdr_acc[63:32]) begin
        v = VERDICT_LENGTH;
      end else if ((crc_acc ^ CrcPreset) != hdr_acc[31:0]) begin
        v = VERDICT_CRC;
      end else begin
        v = VERDICT_OK;
      end
      it.payload_byte = '0;
      it.is_verdict   = 1'b1;
      it.verdict      = v;
      due_items.insert(due_items.size(), it);
      hdr_acc   = '0;
      rec_count = '0;
      crc_acc   = CrcPreset;
    end
  endfunction

  function automatic void push_record(input byte_q_t bytes);
    rec_byte_t rb;
    foreach (bytes[i]) begin
      rb.data = bytes[i];
      rb.last = (i == bytes.size() - 1);
      queued_bytes.insert(queued_bytes.size(), rb);
    end
  endfunction

  function automatic void push_framed(input byte_q_t payload, input logic [31:0] crc_fld,
                                      input logic [31:0] len_fld);
    byte_q_t r;
    for (int k = 0; k < 4; k++) r.insert(r.size(), crc_fld[8*k +: 8]);
    for (int k = 0; k < 4; k++) r.insert(r.size(), len_fld[8*k +: 8]);
    foreach (payload[i]) r.insert(r.size(), payload[i]);
    push_record(r);
  endfunction

  function automatic void add_random_records(input int unsigned target);
    int unsigned added;
    int unsigned plen;
    int unsigned kind;
    logic [31:0] crc_fld;
    logic [31:0] len_fld;
    byte_q_t     body;
    added = 0;
    while (added < target) begin
      body.delete();
      kind = $urandom_range(99);
      if (kind >= 85) begin
        // truncated inside the header
        plen = $urandom_range(1, HeaderLen - 1);
        repeat (plen) body.insert(body.size(), 8'($urandom()));
        push_record(body);
        added += plen;
      end else begin
        plen = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(12);
        repeat (plen) body.insert(body.size(), 8'($urandom()));
        crc_fld = crc32_of(body);
        len_fld = plen;
        if (kind >= 70) begin
          case ($urandom_range(2))
            0:       len_fld = plen + $urandom_range(1, 3);
            1:       len_fld = (plen != 0) ? plen - 1 : 32'hFFFF_FFFF;
            default: len_fld = $urandom();
          endcase
        end else if (kind >= 55) begin
          crc_fld ^= 32'd1 << $urandom_range(31);
        end
        push_framed(body, crc_fld, len_fld);
        added += plen + HeaderLen;
      end
    end
  endfunction

  task automatic drain();
    while (queued_bytes.size() != 0 || rec_if.valid) @(posedge clk);
    while (due_items.size() != 0) @(negedge clk);
  endtask

  // input driver
  always @(negedge clk) begin
    if (rst_n && (!rec_if.valid || rec_taken)) begin
      if (queued_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        next_byte = queued_bytes.pop_front();
        rec_if.valid         <= 1'b1;
        rec_if.data_byte     <= next_byte.data;
        rec_if.end_of_record <= next_byte.last;
      end else begin
        rec_if.valid <= 1'b0;
      end
    end
  end

  // result receiver
  always @(negedge clk) begin
    res_if.ready <= !(hold_go && hold_left != 0) && ($urandom_range(99) >= recv_idle_pct);
  end

  // long hold-off on the result side
  always @(posedge clk) begin
    if (hold_go && hold_left != 0) hold_left <= hold_left - 1;
  end

  // monitor and checker
  always @(posedge clk) begin
    rec_taken <= rec_if.valid && rec_if.ready;
    if (rec_if.valid && rec_if.ready) track_record_byte(rec_if.data_byte, rec_if.end_of_record);
    if (res_if.valid && res_if.ready) begin
      if (due_items.size() == 0) begin
        $display("%0t: unexpected result: byte %02h flag %b verdict %0d", $time,
                 res_if.payload_byte, res_if.is_verdict, res_if.verdict);
        err_count++;
      end else begin
        oldest_due = due_items.pop_front();
        if (res_if.payload_byte !== oldest_due.payload_byte ||
            res_if.is_verdict !== oldest_due.is_verdict ||
            res_if.verdict !== oldest_due.verdict) begin
          $display("%0t: mismatch: expected %02h/%b/%0d, got %02h/%b/%0d",
                   $time, oldest_due.payload_byte, oldest_due.is_verdict, oldest_due.verdict,
                   res_if.payload_byte, res_if.is_verdict, res_if.verdict);
          err_count++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((rec_if.valid && rec_if.ready) || (res_if.valid && res_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= StallLimit) begin
      $display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    byte_q_t body;
    rst_n                = 1'b0;
    rec_if.valid         = 1'b0;
    rec_if.data_byte     = '0;
    rec_if.end_of_record = 1'b0;
    res_if.ready         = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk) rst_n = 1'b1;
    @(posedge clk);

    // one-byte record, empty good record, empty record with bad CRC,
    // one-byte payload with wrong length
    body = {8'hFF};
    push_record(body);
    body.delete();
    push_framed(body, 32'h0000_0000, 32'd0);
    push_framed(body, 32'hFFFF_FFFF, 32'd0);
    body = {8'h00};
    push_framed(body, crc32_of(body), 32'd2);
    add_random_records(BytesPerPhase);
    drain();

    @(posedge clk);
    send_idle_pct <= 51;
    recv_idle_pct <= 31;
    add_random_records(BytesPerPhase);
    drain();

    @(posedge clk);
    send_idle_pct <= 0;
    recv_idle_pct <= 0;
    hold_go       <= 1'b1;
    add_random_records(BytesPerPhase);
    drain();

    repeat (TailCycles) @(posedge clk);
    @(negedge clk);
    if (due_items.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, due_items.size());
      err_count++;
    end
    if (err_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
